@@ rtl/lrr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrr_pkg: shared types and microcode for the ranged LCG random unit
// Holds the request and response structs, the LCG constants, the datapath
// operations and jump conditions of the control words, and the control ROM.
// ----------------------------------------------------------------------------
package lrr_pkg;

  localparam logic [31:0] LCG_MUL     = 32'd1664525;
  localparam logic [31:0] LCG_ADD     = 32'd1013904223;
  localparam logic [31:0] DRAW_OFFSET = 32'd1073741824;
  localparam logic [31:0] MAX_POS     = 32'h7fff_ffff;
  localparam int          DIV_BITS    = 32;
  localparam int          CNT_W       = $clog2(DIV_BITS);
  localparam int          PC_W        = 4;

  typedef struct packed {
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;
  } req_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               range_error;
  } rsp_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_SPAN,
    OP_SEED,
    OP_ADVANCE,
    OP_DIV_SETUP1,
    OP_DIV_SETUP2,
    OP_DIV_STEP,
    OP_RESULT,
    OP_EMPTY,
    OP_WIDE_ERR,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_NO_REQ,
    COND_EMPTY,
    COND_WIDE,
    COND_DIV_BUSY,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [PC_W-1:0]  target;
  } uop_t;

  localparam logic [PC_W-1:0] PC_LOAD   = 4'd0;
  localparam logic [PC_W-1:0] PC_SPAN   = 4'd1;
  localparam logic [PC_W-1:0] PC_SEED   = 4'd2;
  localparam logic [PC_W-1:0] PC_ADV    = 4'd3;
  localparam logic [PC_W-1:0] PC_WIDE   = 4'd4;
  localparam logic [PC_W-1:0] PC_DIV1S  = 4'd5;
  localparam logic [PC_W-1:0] PC_DIV1   = 4'd6;
  localparam logic [PC_W-1:0] PC_DIV2S  = 4'd7;
  localparam logic [PC_W-1:0] PC_DIV2   = 4'd8;
  localparam logic [PC_W-1:0] PC_RESULT = 4'd9;
  localparam logic [PC_W-1:0] PC_EMPTY  = 4'd10;
  localparam logic [PC_W-1:0] PC_ERR    = 4'd11;
  localparam logic [PC_W-1:0] PC_EMIT   = 4'd12;

  function automatic uop_t microcode(input logic [PC_W-1:0] pc);
    uop_t u;
    u = '{op: OP_NOP, cond: COND_ALWAYS, target: PC_LOAD};
    case (pc)
      PC_LOAD:   u = '{op: OP_LOAD,       cond: COND_NO_REQ,   target: PC_LOAD};
      PC_SPAN:   u = '{op: OP_SPAN,       cond: COND_EMPTY,    target: PC_EMPTY};
      PC_SEED:   u = '{op: OP_SEED,       cond: COND_NEXT,     target: PC_LOAD};
      PC_ADV:    u = '{op: OP_ADVANCE,    cond: COND_NEXT,     target: PC_LOAD};
      PC_WIDE:   u = '{op: OP_NOP,        cond: COND_WIDE,     target: PC_ERR};
      PC_DIV1S:  u = '{op: OP_DIV_SETUP1, cond: COND_NEXT,     target: PC_LOAD};
      PC_DIV1:   u = '{op: OP_DIV_STEP,   cond: COND_DIV_BUSY, target: PC_DIV1};
      PC_DIV2S:  u = '{op: OP_DIV_SETUP2, cond: COND_NEXT,     target: PC_LOAD};
      PC_DIV2:   u = '{op: OP_DIV_STEP,   cond: COND_DIV_BUSY, target: PC_DIV2};
      PC_RESULT: u = '{op: OP_RESULT,     cond: COND_ALWAYS,   target: PC_EMIT};
      PC_EMPTY:  u = '{op: OP_EMPTY,      cond: COND_ALWAYS,   target: PC_EMIT};
      PC_ERR:    u = '{op: OP_WIDE_ERR,   cond: COND_NEXT,     target: PC_LOAD};
      PC_EMIT:   u = '{op: OP_EMIT,       cond: COND_OUT_BUSY, target: PC_EMIT};
      default:   u = '{op: OP_NOP,        cond: COND_ALWAYS,   target: PC_LOAD};
    endcase
    return u;
  endfunction

  function automatic logic [31:0] lcg_next(input logic [31:0] x);
    logic [63:0] prod;
    prod = {32'd0, x} * {32'd0, LCG_MUL};
    return prod[31:0] + LCG_ADD;
  endfunction

endpackage

@@ rtl/lcg_ranged_random_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcg_ranged_random_unit: bounded random numbers from a 32-bit LCG
// A microcoded sequencer steps a small datapath through seeding, the LCG
// advance and two restoring divisions to map a draw onto [low, high].
//
//   Channel   Signals                         Moves
//   req       req_valid, req_ready, req       range_low, range_high
//   rsp       rsp_valid, rsp_ready, rsp       value, range_error
//   cfg       cfg_write, cfg_data             seed_init
//
// An empty range and a range that is too wide skip the divisions; any other
// request runs the two 32-step divisions that share the one-bit-per-cycle
// divider. One request is processed at a time; the next
// request is taken while the previous response waits in its output register.
// A stalled response holds the sequencer at its emit step. Reset is
// synchronous and clears the generator word, the seed and the sequencer.
// ----------------------------------------------------------------------------
module lcg_ranged_random_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  lrr_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output lrr_pkg::rsp_t rsp,
  input  logic          cfg_write,
  input  logic [31:0]   cfg_data
);

  logic [lrr_pkg::PC_W-1:0]  pc;
  logic [lrr_pkg::PC_W-1:0]  pc_next;
  lrr_pkg::uop_t             uop;
  logic [31:0]               seed_init;
  logic [31:0]               gen;
  logic signed [31:0]        lo;
  logic signed [31:0]        hi;
  logic [32:0]               span;
  logic [31:0]               quo;
  logic [31:0]               rem;
  logic [31:0]               den;
  logic [lrr_pkg::CNT_W-1:0] cnt;
  logic signed [31:0]        res;
  logic                      err;
  logic                      req_fire;
  logic                      out_free;
  logic                      cond_true;
  logic [31:0]               mul_in;
  logic [31:0]               mul_out;
  logic [31:0]               draw;
  logic [32:0]               rem_sh;
  logic                      fits;
  logic signed [33:0]        span_wide;
  logic signed [33:0]        sum;

  assign uop      = lrr_pkg::microcode(pc);
  assign out_free = !rsp_valid || rsp_ready;
  assign req_fire = req_valid && req_ready;

  always_comb begin
    req_ready = (uop.op == lrr_pkg::OP_LOAD);
  end

  always_comb begin
    case (uop.cond)
      lrr_pkg::COND_NEXT:     cond_true = 1'b0;
      lrr_pkg::COND_ALWAYS:   cond_true = 1'b1;
      lrr_pkg::COND_NO_REQ:   cond_true = !req_fire;
      lrr_pkg::COND_EMPTY:    cond_true = (hi <= lo);
      lrr_pkg::COND_WIDE:     cond_true = span[32] || span[31];
      lrr_pkg::COND_DIV_BUSY: cond_true = (cnt != '0);
      lrr_pkg::COND_OUT_BUSY: cond_true = !out_free;
      default:                cond_true = 1'b0;
    endcase
    pc_next = cond_true ? uop.target : pc + 1'b1;
  end

  always_comb begin
    mul_in    = (uop.op == lrr_pkg::OP_SEED) ? seed_init : gen;
    mul_out   = lrr_pkg::lcg_next(mul_in);
    draw      = {gen[31], gen[31:1]} + lrr_pkg::DRAW_OFFSET;
    rem_sh    = {rem, quo[31]};
    fits      = (rem_sh >= {1'b0, den});
    span_wide = {{2{hi[31]}}, hi} - {{2{lo[31]}}, lo} + 34'sd1;
    sum       = {{2{lo[31]}}, lo} + $signed({2'b00, quo});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= lrr_pkg::PC_LOAD;
      seed_init <= '0;
      gen       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      pc <= pc_next;
      if (cfg_write) begin
        seed_init <= cfg_data;
      end
      if ((uop.op == lrr_pkg::OP_SEED && gen == '0) || uop.op == lrr_pkg::OP_ADVANCE) begin
        gen <= mul_out;
      end
      if (uop.op == lrr_pkg::OP_EMIT && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (uop.op)
      lrr_pkg::OP_LOAD: begin
        if (req_fire) begin
          lo <= req.range_low;
          hi <= req.range_high;
        end
      end
      lrr_pkg::OP_SPAN: begin
        span <= span_wide[32:0];
      end
      lrr_pkg::OP_DIV_SETUP1: begin
        quo <= lrr_pkg::MAX_POS;
        den <= span[31:0];
        rem <= '0;
        cnt <= '1;
      end
      lrr_pkg::OP_DIV_SETUP2: begin
        den <= quo;
        quo <= draw;
        rem <= '0;
        cnt <= '1;
      end
      lrr_pkg::OP_DIV_STEP: begin
        rem <= fits ? 32'(rem_sh - {1'b0, den}) : rem_sh[31:0];
        quo <= {quo[30:0], fits};
        cnt <= cnt - 1'b1;
      end
      lrr_pkg::OP_RESULT: begin
        res <= (sum > $signed({{2{hi[31]}}, hi})) ? hi : sum[31:0];
        err <= 1'b0;
      end
      lrr_pkg::OP_EMPTY: begin
        res <= lo;
        err <= 1'b0;
      end
      lrr_pkg::OP_WIDE_ERR: begin
        res <= lo;
        err <= 1'b1;
      end
      lrr_pkg::OP_EMIT: begin
        if (out_free) begin
          rsp.value       <= res;
          rsp.range_error <= err;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ verif/lcg_ranged_random_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcg_ranged_random_unit_tb: self-checking bench for the ranged LCG unit
// Requests go in through a bursty valid/ready sender and responses leave
// through a stalling receiver. A scoreboard class tracks the seed register
// and the generator word, predicts each response and compares it field by
// field. Seeds are chosen so the generator returns to its unseeded state
// at the end of most phases, so the seed written after such a phase is exercised.
// ----------------------------------------------------------------------------
module lcg_ranged_random_unit_tb;

  localparam int CYCLE_LIMIT = 600000;
  localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] S_MAX = 32'sh7fff_ffff;
  localparam longint SPAN_MAX = 64'sd2147483647;

  class lrr_scoreboard;
    logic [31:0]   seed_word;
    logic [31:0]   gen_word;
    lrr_pkg::rsp_t expected_rsp[$];
    int            errors;
    int            checked;

    function new();
      seed_word = '0;
      gen_word  = '0;
      errors    = 0;
      checked   = 0;
    endfunction

    function void note_request(lrr_pkg::req_t r);
      longint        lo, hi, span, divisor, draw_l, val;
      logic [31:0]   g, draw;
      lrr_pkg::rsp_t e;
      lo = $signed(r.range_low);
      hi = $signed(r.range_high);
      e.value       = r.range_low;
      e.range_error = 1'b0;
      if (hi > lo) begin
        g = gen_word;
        if (g == 32'd0) begin
          g = lrr_pkg::LCG_MUL * seed_word + lrr_pkg::LCG_ADD;
        end
        g = lrr_pkg::LCG_MUL * g + lrr_pkg::LCG_ADD;
        gen_word = g;
        draw = {g[31], g[31:1]} + lrr_pkg::DRAW_OFFSET;
        span = hi - lo + 1;
        if (span > SPAN_MAX) begin
          e.range_error = 1'b1;
        end else begin
          divisor = SPAN_MAX / span;
          draw_l  = {32'd0, draw};
          val     = lo + draw_l / divisor;
          if (val > hi) begin
            val = hi;
          end
          e.value = val[31:0];
        end
      end
      expected_rsp.push_back(e);
    endfunction

    function void check_response(lrr_pkg::rsp_t a);
      lrr_pkg::rsp_t e;
      checked++;
      if (expected_rsp.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("response %0d arrived with no request pending: value %0d error %0b",
                   checked, a.value, a.range_error);
        end
      end else begin
        e = expected_rsp.pop_front();
        if (a.value !== e.value || a.range_error !== e.range_error) begin
          errors++;
          if (errors <= 10) begin
            $display("response %0d: expected value %0d error %0b, got value %0d error %0b",
                     checked, e.value, e.range_error, a.value, a.range_error);
          end
        end
      end
    endfunction
  endclass

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_ready;
  lrr_pkg::req_t req       = '0;
  logic          rsp_valid;
  logic          rsp_ready = 1'b0;
  lrr_pkg::rsp_t rsp;
  logic          cfg_write = 1'b0;
  logic [31:0]   cfg_data  = '0;

  lrr_scoreboard sb;
  int  cycle_count = 0;
  int  burst_left  = 0;
  bit  gap_on      = 1'b0;
  int  ready_mode  = 0;
  int  ready_run   = 0;
  bit  ready_level = 1'b0;

  lcg_ranged_random_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("lcg_ranged_random_unit: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      sb.check_response(rsp);
    end
    if (ready_mode == 0) begin
      rsp_ready <= 1'b1;
    end else if (ready_mode == 1) begin
      rsp_ready <= ($urandom_range(0, 3) != 0);
    end else begin
      if (ready_run == 0) begin
        ready_level = ~ready_level;
        ready_run   = ready_level ? $urandom_range(1, 20) : $urandom_range(1, 30);
      end else begin
        ready_run--;
      end
      rsp_ready <= ready_level;
    end
  end

  // Seed that brings an unseeded generator back to zero after the given
  // number of advancing requests, found by stepping the LCG backwards.
  function automatic logic [31:0] home_seed(int steps);
    logic [31:0] inv_mul, y;
    inv_mul = lrr_pkg::LCG_MUL;
    repeat (5) inv_mul = inv_mul * (32'd2 - lrr_pkg::LCG_MUL * inv_mul);
    y = '0;
    repeat (steps + 1) y = (y - lrr_pkg::LCG_ADD) * inv_mul;
    return y;
  endfunction

  function automatic lrr_pkg::req_t random_request();
    int            kind, b;
    longint        lo, hi, span, mask, a2;
    lrr_pkg::req_t r;
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      lo = $signed($urandom);
      a2 = $signed($urandom);
      if (kind < 4) begin
        hi = lo;
      end else if (a2 <= lo) begin
        hi = a2;
      end else begin
        hi = lo;
        lo = a2;
      end
    end else if (kind < 22) begin
      lo = -longint'($urandom_range(1, 32'h8000_0000));
      hi = lo + SPAN_MAX + longint'($urandom_range(0, 32'(-lo)));
    end else if (kind < 32) begin
      lo = $signed($urandom);
      hi = $signed($urandom);
    end else begin
      b    = (kind < 70) ? $urandom_range(1, 12) : $urandom_range(13, 31);
      mask = (longint'(1) << b) - 1;
      span = (longint'($urandom) & mask) + 1;
      if (span > SPAN_MAX) begin
        span = SPAN_MAX;
      end
      lo = $signed($urandom);
      if (lo + span - 1 > SPAN_MAX) begin
        lo = SPAN_MAX - span + 1;
      end
      hi = lo + span - 1;
    end
    r.range_low  = lo[31:0];
    r.range_high = hi[31:0];
    return r;
  endfunction

  task automatic send_request(input lrr_pkg::req_t r);
    if (gap_on && burst_left == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (!req_ready);
    sb.note_request(r);
    if (burst_left > 0) begin
      burst_left--;
    end
  endtask

  task automatic begin_phase(input logic [31:0] seed, input bit quiet);
    cfg_write <= 1'b1;
    cfg_data  <= seed;
    @(posedge clk);
    sb.seed_word = seed;
    cfg_write  <= 1'b0;
    gap_on     = quiet ? 1'b0 : 1'(($urandom_range(0, 2)) != 0);
    ready_mode = quiet ? 0 : $urandom_range(0, 2);
    burst_left = 0;
  endtask

  task automatic finish_phase();
    req_valid <= 1'b0;
    while (sb.expected_rsp.size() != 0) @(posedge clk);
  endtask

  initial begin
    lrr_pkg::req_t directed[$];
    lrr_pkg::req_t r;
    int            advancing;
    int            moved;

    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed.push_back('{range_low: 32'sd0,         range_high: 32'sd0});
    directed.push_back('{range_low: 32'sd5,         range_high: 32'sd3});
    directed.push_back('{range_low: S_MIN,          range_high: S_MIN});
    directed.push_back('{range_low: S_MAX,          range_high: S_MAX});
    directed.push_back('{range_low: S_MAX,          range_high: S_MIN});
    directed.push_back('{range_low: S_MIN,          range_high: S_MAX});
    directed.push_back('{range_low: -32'sd1,        range_high: S_MAX});
    directed.push_back('{range_low: 32'sd0,         range_high: S_MAX});
    directed.push_back('{range_low: 32'sd1,         range_high: S_MAX});
    directed.push_back('{range_low: S_MIN,          range_high: -32'sd1});
    directed.push_back('{range_low: S_MIN,          range_high: -32'sd2});
    directed.push_back('{range_low: S_MIN,          range_high: 32'sd0});
    directed.push_back('{range_low: 32'sd0,         range_high: 32'sd1});
    directed.push_back('{range_low: S_MIN,          range_high: S_MIN + 32'sd1});
    directed.push_back('{range_low: S_MAX - 32'sd1, range_high: S_MAX});
    directed.push_back('{range_low: -32'sd1,        range_high: 32'sd0});
    directed.push_back('{range_low: 32'sd0,         range_high: 32'sh4000_0000});
    directed.push_back('{range_low: -32'sd100,      range_high: 32'sd100});
    directed.push_back('{range_low: 32'sd0,         range_high: 32'sd1000000});
    directed.push_back('{range_low: -32'sd7,        range_high: -32'sd3});
    directed.push_back('{range_low: S_MAX,          range_high: 32'sd0});
    directed.push_back('{range_low: 32'sd1000,      range_high: 32'sd999});

    advancing = 0;
    foreach (directed[i]) begin
      if ($signed(directed[i].range_high) > $signed(directed[i].range_low)) begin
        advancing++;
      end
    end
    begin_phase(home_seed(advancing), 1'b1);
    foreach (directed[i]) send_request(directed[i]);
    finish_phase();

    // Every advancing request leaves the generator at zero, so each one
    // reseeds from this value.
    begin_phase(home_seed(1), 1'b0);
    repeat (12) send_request(random_request());
    finish_phase();

    repeat (3) begin
      begin_phase(home_seed($urandom_range(100, 160)), 1'b0);
      moved = 0;
      do begin
        r = random_request();
        send_request(r);
        if ($signed(r.range_high) > $signed(r.range_low)) begin
          moved++;
        end
      end while (moved == 0 || sb.gen_word != 32'd0);
      finish_phase();
    end

    // Seeding itself yields zero here, so the first advance runs on zero.
    begin_phase(home_seed(0), 1'b0);
    repeat (200) send_request(random_request());
    finish_phase();

    begin_phase(32'h0000_0000, 1'b0);
    repeat (60) send_request(random_request());
    finish_phase();

    begin_phase(32'hffff_ffff, 1'b0);
    repeat (60) send_request(random_request());
    finish_phase();

    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.expected_rsp.size() == 0) begin
      $display("lcg_ranged_random_unit: match");
    end else begin
      $display("lcg_ranged_random_unit: mismatch");
    end
    $finish;
  end

endmodule
